// File: rtl/core/mepd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mepd_pkg: shared types and constants
// Beat layouts, drive latch, frame decode info and register indexes for the
// multiturn encoder position drive.
// ----------------------------------------------------------------------------
package mepd_pkg;

    localparam int FRAME_W = 16;
    localparam int POS_W   = 10;
    localparam int TURNS_W = 16;
    localparam int GOAL_W  = 7;
    localparam int DUTY_W  = 7;
    localparam int THR_W   = 10;

    // Encoder frame fields
    localparam int POS_LSB    = 6;
    localparam int STATUS_LSB = 1;
    localparam int STATUS_W   = 5;
    localparam logic [STATUS_W-1:0] STATUS_OK_A = 5'd16;
    localparam logic [STATUS_W-1:0] STATUS_OK_B = 5'd17;
    localparam logic [STATUS_W-1:0] STATUS_OK_C = 5'd18;

    localparam logic [DUTY_W-1:0]  DUTY_MAX      = 7'd100;
    localparam logic [THR_W-1:0]   THR_RESET     = 10'd450;
    localparam logic [DUTY_W-1:0]  DUTY_RESET    = 7'd90;
    localparam logic [TURNS_W-1:0] TURNS_RESET   = 16'd1;
    localparam logic [GOAL_W-1:0]  GOAL_RESET    = 7'd1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_DUTY     = 1'b1;
    localparam int CFG_DATA_W = 10;

    // Input beat, lowest field last
    typedef struct packed {
        logic [6:0]         pad;
        logic               manual_mode;
        logic [GOAL_W-1:0]  target_turns;
        logic               load_target;
        logic [FRAME_W-1:0] raw_frame;
    } in_beat_t;

    // Result beat, lowest field last
    typedef struct packed {
        logic [1:0]         pad;
        logic               at_target;
        logic               brake_on;
        logic [DUTY_W-1:0]  motor_pwm;
        logic               motor_down;
        logic               motor_on;
        logic [TURNS_W-1:0] turns;
        logic [POS_W-1:0]   position;
        logic               frame_ok;
    } out_beat_t;

    localparam int IN_W  = $bits(in_beat_t);
    localparam int OUT_W = $bits(out_beat_t);

    // Latched drive outputs
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              brake;
        logic              down;
        logic              on;
    } latch_t;

    // Frame decode result handed to the tracker
    typedef struct packed {
        logic             ok;
        logic             decide;
        logic             step_up;
        logic             step_dn;
        logic [POS_W-1:0] pos;
    } frame_info_t;

endpackage

// File: rtl/core/multiturn_encoder_position_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiturn_encoder_position_drive: multiturn encoder tracker with drive latch
// Decodes absolute encoder frames, counts turn wraps and latches a bang-bang
// motor drive toward a target turn count.
//
// Channel  Dir  Beat contents (lowest bit first)
// s_axis   in   raw_frame[15:0], load_target, target_turns[6:0], manual_mode
// m_axis   out  frame_ok, position[9:0], turns[15:0], motor_on, motor_down,
//               motor_pwm[6:0], brake_on, at_target
// cfg      in   cfg_index 0 jump_threshold, 1 drive_duty
//
// One beat per cycle while the output is not stalled; a result appears in the cycle after its input beat.
// All decode and drive work sits between the accepted beat and the result
// register, so state is updated at the accept edge.
// s_tready is low only while a result is held and m_tready is low.
// Reset loads the state reset values and clears the result valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module multiturn_encoder_position_drive (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // raw_frame[15:0], load_target[16], target_turns[23:17], manual_mode[24]
    input  logic [mepd_pkg::IN_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // frame_ok[0], position[10:1], turns[26:11], motor_on[27], motor_down[28],
    // motor_pwm[35:29], brake_on[36], at_target[37]
    output logic [mepd_pkg::OUT_W-1:0]        m_tdata,
    input  logic                              cfg_we,
    input  logic [mepd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mepd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mepd_pkg::in_beat_t             in_beat;
    mepd_pkg::frame_info_t          info;
    logic                           accept;

    logic [mepd_pkg::THR_W-1:0]     thr_reg;
    logic [mepd_pkg::DUTY_W-1:0]    duty_reg;
    logic [mepd_pkg::POS_W-1:0]     prev_pos_reg;
    logic                           prev_valid_reg;
    logic [mepd_pkg::TURNS_W-1:0]   turns_reg;
    logic [mepd_pkg::TURNS_W-1:0]   turns_next;
    logic [mepd_pkg::GOAL_W-1:0]    goal_reg;
    logic [mepd_pkg::GOAL_W-1:0]    goal_next;
    logic                           arrived_reg;
    logic                           arrived_next;
    mepd_pkg::latch_t               latch_reg;
    mepd_pkg::latch_t               latch_next;
    logic [mepd_pkg::POS_W-1:0]     pos_next;

    mepd_pkg::out_beat_t            out_reg;
    mepd_pkg::out_beat_t            out_next;
    logic                           out_valid_reg;

    assign in_beat  = mepd_pkg::in_beat_t'(s_tdata);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    mepd_frame_dec u_dec (
        .raw_frame      (in_beat.raw_frame),
        .prev_position  (prev_pos_reg),
        .prev_valid     (prev_valid_reg),
        .jump_threshold (thr_reg),
        .info           (info)
    );

    mepd_track u_track (
        .info            (info),
        .manual_mode     (in_beat.manual_mode),
        .load_target     (in_beat.load_target),
        .target_turns    (in_beat.target_turns),
        .drive_duty      (duty_reg),
        .turn_count      (turns_reg),
        .goal_turns      (goal_reg),
        .arrived         (arrived_reg),
        .latch           (latch_reg),
        .turn_count_next (turns_next),
        .goal_turns_next (goal_next),
        .arrived_next    (arrived_next),
        .latch_next      (latch_next)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= mepd_pkg::THR_RESET;
            duty_reg <= mepd_pkg::DUTY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mepd_pkg::REG_JUMP_THRESHOLD: thr_reg  <= cfg_data[mepd_pkg::THR_W-1:0];
                mepd_pkg::REG_DRIVE_DUTY:     duty_reg <= cfg_data[mepd_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Result beat assembly
    assign pos_next = info.ok ? info.pos : prev_pos_reg;

    always_comb
    begin
        out_next            = '0;
        out_next.frame_ok   = info.ok;
        out_next.position   = pos_next;
        out_next.turns      = turns_next;
        out_next.motor_on   = latch_next.on;
        out_next.motor_down = latch_next.down;
        out_next.motor_pwm  = latch_next.duty;
        out_next.brake_on   = latch_next.brake;
        out_next.at_target  = arrived_next;
    end

    // Tracker state, updated per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg   <= '0;
            prev_valid_reg <= 1'b0;
            turns_reg      <= mepd_pkg::TURNS_RESET;
            goal_reg       <= mepd_pkg::GOAL_RESET;
            arrived_reg    <= 1'b0;
            latch_reg      <= '0;
        end
        else if (accept)
        begin
            prev_pos_reg   <= pos_next;
            prev_valid_reg <= prev_valid_reg || info.ok;
            turns_reg      <= turns_next;
            goal_reg       <= goal_next;
            arrived_reg    <= arrived_next;
            latch_reg      <= latch_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/core/mepd_frame_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mepd_frame_dec: encoder frame decode and jump test
// Checks the status field, extracts the position and compares it against the
// last position to detect a turn wrap in either direction.
// ----------------------------------------------------------------------------
module mepd_frame_dec (
    input  logic [mepd_pkg::FRAME_W-1:0] raw_frame,
    input  logic [mepd_pkg::POS_W-1:0]   prev_position,
    input  logic                         prev_valid,
    input  logic [mepd_pkg::THR_W-1:0]   jump_threshold,
    output mepd_pkg::frame_info_t        info
);

    logic [mepd_pkg::STATUS_W-1:0] status;
    logic [mepd_pkg::POS_W-1:0]    pos;
    logic [mepd_pkg::POS_W:0]      last_plus_thr;
    logic [mepd_pkg::POS_W:0]      pos_plus_thr;
    logic                          ok;

    // Status window and position field
    assign status = raw_frame[mepd_pkg::STATUS_LSB +: mepd_pkg::STATUS_W];
    assign pos    = raw_frame[mepd_pkg::POS_LSB +: mepd_pkg::POS_W];
    assign ok     = (status == mepd_pkg::STATUS_OK_A) ||
                    (status == mepd_pkg::STATUS_OK_B) ||
                    (status == mepd_pkg::STATUS_OK_C);

    // Jump compare without wrap, one extra bit for the sums
    assign last_plus_thr = {1'b0, prev_position} + {1'b0, jump_threshold};
    assign pos_plus_thr  = {1'b0, pos} + {1'b0, jump_threshold};

    always_comb
    begin
        info.ok      = ok;
        info.decide  = ok && prev_valid;
        info.pos     = pos;
        info.step_up = ok && prev_valid && ({1'b0, pos} > last_plus_thr);
        info.step_dn = ok && prev_valid && !({1'b0, pos} > last_plus_thr) &&
                       (pos_plus_thr < {1'b0, prev_position});
    end

endmodule

// File: rtl/core/mepd_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mepd_track: turn counter and bang-bang drive decision
// Steps the wrapping turn count, compares it with the goal and chooses
// up, down or stop with brake, tracking the arrival flag.
// ----------------------------------------------------------------------------
module mepd_track (
    input  mepd_pkg::frame_info_t         info,
    input  logic                          manual_mode,
    input  logic                          load_target,
    input  logic [mepd_pkg::GOAL_W-1:0]   target_turns,
    input  logic [mepd_pkg::DUTY_W-1:0]   drive_duty,
    input  logic [mepd_pkg::TURNS_W-1:0]  turn_count,
    input  logic [mepd_pkg::GOAL_W-1:0]   goal_turns,
    input  logic                          arrived,
    input  mepd_pkg::latch_t              latch,
    output logic [mepd_pkg::TURNS_W-1:0]  turn_count_next,
    output logic [mepd_pkg::GOAL_W-1:0]   goal_turns_next,
    output logic                          arrived_next,
    output mepd_pkg::latch_t              latch_next
);

    logic [mepd_pkg::DUTY_W-1:0]  duty_sat;
    logic [mepd_pkg::TURNS_W-1:0] goal_wide;
    logic                         arr_mid;

    // Duty clipped to full scale
    assign duty_sat  = (drive_duty > mepd_pkg::DUTY_MAX) ? mepd_pkg::DUTY_MAX : drive_duty;
    assign goal_wide = {{(mepd_pkg::TURNS_W - mepd_pkg::GOAL_W){1'b0}}, goal_turns_next};

    // Target load and turn step
    always_comb
    begin
        goal_turns_next = load_target ? target_turns : goal_turns;
        turn_count_next = turn_count;
        arr_mid         = load_target ? 1'b0 : arrived;
        if (info.step_up)
        begin
            turn_count_next = turn_count + 1'b1;
            arr_mid         = 1'b0;
        end
        else if (info.step_dn)
        begin
            turn_count_next = turn_count - 1'b1;
            arr_mid         = 1'b0;
        end
    end

    // Drive decision
    always_comb
    begin
        latch_next   = latch;
        arrived_next = arr_mid;
        if (info.decide && !arr_mid && !manual_mode)
        begin
            if (goal_wide > turn_count_next)
            begin
                latch_next = '{duty: duty_sat, brake: 1'b0, down: 1'b0, on: 1'b1};
            end
            else if (goal_wide < turn_count_next)
            begin
                latch_next = '{duty: duty_sat, brake: 1'b0, down: 1'b1, on: 1'b1};
            end
            else
            begin
                latch_next   = '{duty: '0, brake: 1'b1, down: 1'b0, on: 1'b0};
                arrived_next = 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/mepd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mepd_checker: port-level checks for the position drive
// Watches the stream ports and the drive fields of each result beat.
// ----------------------------------------------------------------------------
module mepd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [mepd_pkg::OUT_W-1:0] m_tdata
);

    mepd_pkg::out_beat_t beat;

    assign beat = mepd_pkg::out_beat_t'(m_tdata);

    // Held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Every accepted beat yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat produced no result");

    // Brake and motor never on together
    a_brake: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(beat.motor_on && beat.brake_on))
        else $error("brake engaged while motor on");

    // Running duty within full scale, stopped drive is idle
    a_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (beat.motor_on ? (beat.motor_pwm <= mepd_pkg::DUTY_MAX)
                                    : (beat.motor_pwm == '0 && !beat.motor_down)))
        else $error("drive duty out of range");

endmodule

bind multiturn_encoder_position_drive mepd_checker u_mepd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/tb_multiturn_encoder_position_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiturn_encoder_position_drive: regression bench for the encoder drive
// Streams encoder frames into the block and tracks turns, arrival and the
// drive latch in a local model. Every result beat is checked field by field
// against the model. The run steps through several register settings and
// idles both stream sides at random, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_multiturn_encoder_position_drive;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int ITEMS_PER_PHASE = 360;
    localparam int LONG_HOLD       = 150;
    localparam int HOLD_AFTER      = 300;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    // raw_frame[15:0], load_target[16], target_turns[23:17], manual_mode[24]
    mepd_pkg::in_beat_t              s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // frame_ok[0], position[10:1], turns[26:11], motor_on[27], motor_down[28],
    // motor_pwm[35:29], brake_on[36], at_target[37]
    mepd_pkg::out_beat_t             m_tdata;
    logic                            cfg_we    = 1'b0;
    logic [mepd_pkg::CFG_IDX_W-1:0]  cfg_index = mepd_pkg::REG_JUMP_THRESHOLD;
    logic [mepd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    multiturn_encoder_position_drive DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of registers and tracker state
    logic [mepd_pkg::THR_W-1:0]   thr_setting  = mepd_pkg::THR_RESET;
    logic [mepd_pkg::DUTY_W-1:0]  duty_setting = mepd_pkg::DUTY_RESET;
    logic [mepd_pkg::POS_W-1:0]   prev_sample  = '0;
    logic                         pos_seen     = 1'b0;
    logic [mepd_pkg::TURNS_W-1:0] turn_cnt     = mepd_pkg::TURNS_RESET;
    logic [mepd_pkg::GOAL_W-1:0]  goal         = mepd_pkg::GOAL_RESET;
    logic                         arrived      = 1'b0;
    mepd_pkg::latch_t             drive        = '0;

    mepd_pkg::in_beat_t  frame_queue[$];
    mepd_pkg::out_beat_t predicted_status[$];
    mepd_pkg::out_beat_t status_want;

    int  queued_cnt   = 0;
    int  beats_in     = 0;
    int  results_seen = 0;
    int  errors       = 0;
    int  turn_steps   = 0;
    int  arrivals     = 0;
    int  phases       = 0;
    int  cycle_cnt    = 0;
    int  walk_pos     = 0;
    int  walk_dir     = 1;
    int  send_gap     = 0;
    int  recv_gap     = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    bit  send_bursty  = 1'b1;
    bit  recv_bursty  = 1'b1;
    bit  steady_tail  = 1'b0;
    logic beat_taken  = 1'b0;

    always #(CLK_HALF) clk = ~clk;

    // Tracker model: one frame in, one status beat out
    function automatic mepd_pkg::out_beat_t track_frame(mepd_pkg::in_beat_t beat);
        logic [mepd_pkg::STATUS_W-1:0] status;
        logic                          ok;
        int                            pos;
        int                            prev;
        int                            thr;
        int                            goal_i;
        int                            turns_i;
        mepd_pkg::out_beat_t           res;
        status = beat.raw_frame[mepd_pkg::POS_LSB-1:mepd_pkg::STATUS_LSB];
        ok = (status == mepd_pkg::STATUS_OK_A) || (status == mepd_pkg::STATUS_OK_B) ||
             (status == mepd_pkg::STATUS_OK_C);
        // a target load lands even on a bad frame
        if (beat.load_target)
        begin
            goal    = beat.target_turns;
            arrived = 1'b0;
        end
        if (ok)
        begin
            pos = int'(beat.raw_frame[mepd_pkg::FRAME_W-1:mepd_pkg::POS_LSB]);
            if (pos_seen)
            begin
                prev = int'(prev_sample);
                thr  = int'(thr_setting);
                // unwrapped compare against the last sample
                if (pos > prev + thr)
                begin
                    turn_cnt = turn_cnt + 16'd1;
                    arrived  = 1'b0;
                    turn_steps++;
                end
                else if (pos + thr < prev)
                begin
                    turn_cnt = turn_cnt - 16'd1;
                    arrived  = 1'b0;
                    turn_steps++;
                end
                if (!arrived && !beat.manual_mode)
                begin
                    goal_i  = int'(goal);
                    turns_i = int'(turn_cnt);
                    if (goal_i != turns_i)
                    begin
                        drive.on    = 1'b1;
                        drive.down  = (goal_i < turns_i);
                        drive.brake = 1'b0;
                        drive.duty  = (duty_setting > mepd_pkg::DUTY_MAX) ?
                                      mepd_pkg::DUTY_MAX : duty_setting;
                    end
                    else
                    begin
                        drive       = '0;
                        drive.brake = 1'b1;
                        arrived     = 1'b1;
                        arrivals++;
                    end
                end
            end
            prev_sample = beat.raw_frame[mepd_pkg::FRAME_W-1:mepd_pkg::POS_LSB];
            pos_seen    = 1'b1;
        end
        res            = '0;
        res.frame_ok   = ok;
        res.position   = prev_sample;
        res.turns      = turn_cnt;
        res.motor_on   = drive.on;
        res.motor_down = drive.down;
        res.motor_pwm  = drive.duty;
        res.brake_on   = drive.brake;
        res.at_target  = arrived;
        return res;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Rising edge: check result beats, then predict accepted input beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (predicted_status.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    status_want = predicted_status.pop_front();
                    check_field("frame_ok",   int'(status_want.frame_ok),
                                int'(m_tdata.frame_ok));
                    check_field("position",   int'(status_want.position),
                                int'(m_tdata.position));
                    check_field("turns",      int'(status_want.turns),
                                int'(m_tdata.turns));
                    check_field("motor_on",   int'(status_want.motor_on),
                                int'(m_tdata.motor_on));
                    check_field("motor_down", int'(status_want.motor_down),
                                int'(m_tdata.motor_down));
                    check_field("motor_pwm",  int'(status_want.motor_pwm),
                                int'(m_tdata.motor_pwm));
                    check_field("brake_on",   int'(status_want.brake_on),
                                int'(m_tdata.brake_on));
                    check_field("at_target",  int'(status_want.at_target),
                                int'(m_tdata.at_target));
                end
            end
            if (s_tvalid && s_tready)
            begin
                predicted_status.push_back(track_frame(s_tdata));
                beats_in++;
            end
            beat_taken <= s_tvalid && s_tready;
        end
    end

    // Input driver: holds a beat until taken, idles in short bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0)
                send_bursty = !send_bursty;
            if (s_tvalid && !beat_taken)
            begin
                // beat still pending
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (frame_queue.size() == 0)
            begin
                s_tvalid <= 1'b0;
            end
            else if (send_bursty && !steady_tail && $urandom_range(0, 4) == 0)
            begin
                send_gap = $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tdata  <= frame_queue.pop_front();
                s_tvalid <= 1'b1;
            end
        end
    end

    // Output side: random stalls plus one long hold-off to back up the input
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0)
                recv_bursty = !recv_bursty;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else if (recv_bursty && !steady_tail && $urandom_range(0, 4) == 0)
            begin
                recv_gap = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_cnt, predicted_status.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [mepd_pkg::FRAME_W-1:0] make_frame(
        logic [mepd_pkg::POS_W-1:0]    pos,
        logic [mepd_pkg::STATUS_W-1:0] status,
        logic                          lsb);
        return {pos, status, lsb};
    endfunction

    task automatic push_frame(logic [mepd_pkg::FRAME_W-1:0] raw, logic ld,
                              logic [mepd_pkg::GOAL_W-1:0] tgt, logic man);
        mepd_pkg::in_beat_t beat;
        beat              = '0;
        beat.raw_frame    = raw;
        beat.load_target  = ld;
        beat.target_turns = tgt;
        beat.manual_mode  = man;
        frame_queue.push_back(beat);
        queued_cnt++;
    endtask

    // Mostly a smooth encoder walk, with bad frames, noise and big jumps mixed in
    task automatic queue_random(int count);
        int                            kind;
        int                            step;
        logic [mepd_pkg::FRAME_W-1:0]  raw;
        logic [mepd_pkg::STATUS_W-1:0] st;
        logic                          ld;
        logic [mepd_pkg::GOAL_W-1:0]   tgt;
        logic                          man;
        repeat (count)
        begin
            kind = $urandom_range(0, 99);
            ld   = ($urandom_range(0, 24) == 0);
            tgt  = ($urandom_range(0, 3) == 0) ? mepd_pkg::GOAL_W'($urandom_range(0, 127)) :
                                                 mepd_pkg::GOAL_W'($urandom_range(0, 6));
            man  = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 29) == 0)
                walk_dir = -walk_dir;
            if (kind < 78)
            begin
                step     = $urandom_range(0, 40);
                walk_pos = (walk_pos + walk_dir * step + 1024) % 1024;
                raw = make_frame(mepd_pkg::POS_W'(walk_pos),
                                 mepd_pkg::STATUS_W'(mepd_pkg::STATUS_OK_A +
                                                     $urandom_range(0, 2)),
                                 1'($urandom_range(0, 1)));
            end
            else if (kind < 86)
            begin
                st = mepd_pkg::STATUS_W'($urandom_range(0, 28));
                if (st >= mepd_pkg::STATUS_OK_A)
                    st = st + 5'd3;
                raw = make_frame(mepd_pkg::POS_W'($urandom_range(0, 1023)), st,
                                 1'($urandom_range(0, 1)));
            end
            else if (kind < 92)
            begin
                raw = mepd_pkg::FRAME_W'($urandom_range(0, 65535));
            end
            else
            begin
                walk_pos = $urandom_range(0, 1023);
                raw = make_frame(mepd_pkg::POS_W'(walk_pos),
                                 mepd_pkg::STATUS_W'(mepd_pkg::STATUS_OK_A +
                                                     $urandom_range(0, 2)),
                                 1'($urandom_range(0, 1)));
            end
            push_frame(raw, ld, tgt, man);
        end
    endtask

    task automatic wait_idle();
        while (beats_in < queued_cnt || predicted_status.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_registers(logic [mepd_pkg::THR_W-1:0] thr,
                                 logic [mepd_pkg::DUTY_W-1:0] duty);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= mepd_pkg::REG_JUMP_THRESHOLD;
        cfg_data  <= thr;
        @(negedge clk);
        cfg_index <= mepd_pkg::REG_DRIVE_DUTY;
        cfg_data  <= mepd_pkg::CFG_DATA_W'(duty);
        @(negedge clk);
        cfg_we    <= 1'b0;
        thr_setting  = thr;
        duty_setting = duty;
    endtask

    task automatic run_phase();
        phases++;
        queue_random(ITEMS_PER_PHASE);
        wait_idle();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames at reset settings
        // bad frame, no sample yet
        push_frame(16'h0000, 1'b1, 7'd3, 1'b0);
        // first sample only
        push_frame(make_frame(10'd0, mepd_pkg::STATUS_OK_A, 1'b0), 1'b0, 7'd0, 1'b0);
        // count up
        push_frame(make_frame(10'd1023, mepd_pkg::STATUS_OK_B, 1'b1), 1'b0, 7'd0, 1'b0);
        // count down
        push_frame(make_frame(10'd0, mepd_pkg::STATUS_OK_C, 1'b0), 1'b0, 7'd0, 1'b0);
        // jump equals threshold
        push_frame(make_frame(10'd450, mepd_pkg::STATUS_OK_A, 1'b0), 1'b0, 7'd0, 1'b0);
        // bad frame, target loads
        push_frame(16'hFFFF, 1'b1, 7'd127, 1'b0);
        // status just below
        push_frame(make_frame(10'd900, 5'd15, 1'b1), 1'b0, 7'd0, 1'b0);
        // status just above
        push_frame(make_frame(10'd900, 5'd19, 1'b0), 1'b0, 7'd0, 1'b0);
        // on goal, brake
        push_frame(make_frame(10'd0, mepd_pkg::STATUS_OK_A, 1'b0), 1'b1, 7'd1, 1'b0);
        // arrived, hold
        push_frame(make_frame(10'd5, mepd_pkg::STATUS_OK_B, 1'b0), 1'b0, 7'd0, 1'b0);
        // manual with new goal
        push_frame(make_frame(10'd5, mepd_pkg::STATUS_OK_A, 1'b0), 1'b1, 7'd0, 1'b1);
        push_frame(make_frame(10'd400, mepd_pkg::STATUS_OK_A, 1'b0), 1'b0, 7'd0, 1'b0);
        push_frame(make_frame(10'd800, mepd_pkg::STATUS_OK_C, 1'b1), 1'b0, 7'd0, 1'b0);
        // down to zero turns
        push_frame(make_frame(10'd300, mepd_pkg::STATUS_OK_A, 1'b0), 1'b0, 7'd0, 1'b0);
        push_frame(make_frame(10'd700, mepd_pkg::STATUS_OK_B, 1'b0), 1'b0, 7'd0, 1'b0);
        // wraps to all ones
        push_frame(make_frame(10'd200, mepd_pkg::STATUS_OK_A, 1'b0), 1'b0, 7'd0, 1'b0);
        // wraps back
        push_frame(make_frame(10'd1023, mepd_pkg::STATUS_OK_C, 1'b1), 1'b1, 7'd127, 1'b0);
        push_frame(make_frame(10'd1023, mepd_pkg::STATUS_OK_A, 1'b1), 1'b0, 7'd0, 1'b1);
        // status zero, max pos
        push_frame(16'hFFC1, 1'b1, 7'd1, 1'b0);
        push_frame(make_frame(10'd512, mepd_pkg::STATUS_OK_B, 1'b1), 1'b0, 7'd0, 1'b0);
        run_phase();

        // Threshold floor, full duty
        set_registers(10'd0, 7'd100);
        run_phase();

        // Threshold ceiling, duty above limit saturates
        set_registers(10'd1023, 7'd127);
        run_phase();

        set_registers(mepd_pkg::THR_W'($urandom_range(1, 1022)),
                      mepd_pkg::DUTY_W'($urandom_range(0, 100)));
        run_phase();

        // Last stretch runs without idling
        steady_tail = 1'b1;
        set_registers(10'd0, 7'd0);
        run_phase();

        $display("Covered %0d frames under %0d register settings: %0d turn steps, %0d arrivals",
                 beats_in, phases, turn_steps, arrivals);
        $display("Output side held off once for %0d cycles while frames kept arriving",
                 LONG_HOLD);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mepd_pkg.sv
rtl/core/mepd_frame_dec.sv
rtl/core/mepd_track.sv
rtl/core/multiturn_encoder_position_drive.sv
rtl/core/mepd_checker.sv
test/tb_multiturn_encoder_position_drive.sv
